[src/clcd_pkg.sv]
`default_nettype none

package clcd_pkg;

    typedef struct packed {
        logic [3:0]  operation;
        logic [6:0]  column;
        logic [3:0]  row;
        logic [7:0]  char_code;
        logic [3:0]  glyph_slot;
        logic [63:0] glyph_rows;
    } in_item_t;

    typedef struct packed {
        logic        register_select;
        logic [3:0]  nibble;
        logic [15:0] wait_before_us;
        logic [10:0] wait_after_us;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        rs;
        logic        long_wait;
        logic [7:0]  byte0;
        logic [7:0]  fn_byte;
        logic [63:0] rows;
    } job_t;

    localparam logic [3:0] OP_INIT         = 4'd0;
    localparam logic [3:0] OP_CLEAR        = 4'd1;
    localparam logic [3:0] OP_HOME         = 4'd2;
    localparam logic [3:0] OP_DISPLAY_ON   = 4'd3;
    localparam logic [3:0] OP_DISPLAY_OFF  = 4'd4;
    localparam logic [3:0] OP_CURSOR_ON    = 4'd5;
    localparam logic [3:0] OP_CURSOR_OFF   = 4'd6;
    localparam logic [3:0] OP_BLINK_ON     = 4'd7;
    localparam logic [3:0] OP_BLINK_OFF    = 4'd8;
    localparam logic [3:0] OP_SCROLL_LEFT  = 4'd9;
    localparam logic [3:0] OP_SCROLL_RIGHT = 4'd10;
    localparam logic [3:0] OP_SET_CURSOR   = 4'd11;
    localparam logic [3:0] OP_WRITE_CHAR   = 4'd12;
    localparam logic [3:0] OP_DEFINE_GLYPH = 4'd13;

    localparam logic [1:0] JOB_SINGLE = 2'd0;
    localparam logic [1:0] JOB_INIT   = 2'd1;
    localparam logic [1:0] JOB_GLYPH  = 2'd2;

    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] CFG_TALL_FONT    = 2'd2;

    localparam logic [7:0] CMD_WAKE         = 8'h03;
    localparam logic [7:0] CMD_FOUR_BIT     = 8'h02;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_DISPLAY_INIT = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_SCROLL_LEFT  = 8'h18;
    localparam logic [7:0] CMD_SCROLL_RIGHT = 8'h1C;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
    localparam logic [7:0] FN_TWO_LINE      = 8'h08;
    localparam logic [7:0] FN_TALL_FONT     = 8'h04;

    localparam logic [15:0] WAIT_WAKE_FIRST  = 16'd50000;
    localparam logic [15:0] WAIT_WAKE_SECOND = 16'd5000;
    localparam logic [15:0] WAIT_WAKE_THIRD  = 16'd150;
    localparam logic [10:0] WAIT_FOUR_BIT    = 11'd1000;
    localparam logic [10:0] WAIT_LONG_CMD    = 11'd2000;

endpackage

`default_nettype wire

[src/char_lcd_nibble_command_sequencer.sv]
// The first nibble of an operation passes the queue slot, the current-job register and the output register.
// Throughput: one nibble per cycle while the output is not stalled; an operation gives
// 2 nibbles, 16 for init and 18 for define glyph, counted by the nibble step counter.
// Operations queue up front, so the next one follows its predecessor with no gap.
// Reset: column_count 16, row_count 2, tall_font 0, all display flags off, queue empty.
`default_nettype none

module char_lcd_nibble_command_sequencer
    import clcd_pkg::*;
#(
    parameter int ROW_CAPACITY = 4,
    parameter int QUEUE_DEPTH  = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data,
    input  wire logic       cfg_wen,
    input  wire logic [1:0] cfg_index,
    input  wire logic [5:0] cfg_data
);

    logic [5:0] column_count_reg;
    logic [2:0] row_count_reg;
    logic       tall_font_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    job_t       push_job;
    job_t       pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 6'd16;
            row_count_reg    <= 3'd2;
            tall_font_reg    <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data[2:0];
                CFG_TALL_FONT:    tall_font_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign in_stall = q_full;

    clcd_front #(
        .ROW_CAPACITY(ROW_CAPACITY)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_data      (in_data),
        .column_count (column_count_reg),
        .row_count    (row_count_reg),
        .tall_font    (tall_font_reg),
        .queue_full   (q_full),
        .push         (q_push),
        .push_job     (push_job)
    );

    clcd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    clcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full && !q_pop))
        else $error("Operation queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("Operation queue read while empty.");

    a_data_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.register_select) |->
            (out_data.wait_before_us == 16'd0 && out_data.wait_after_us == 11'd0))
        else $error("Data nibble carries an extra wait.");

    a_wait_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.wait_before_us != 16'd0) |-> !out_data.last)
        else $error("Wait-before nibble marked as the last of its operation.");

endmodule

`default_nettype wire

[src/clcd_front.sv]
`default_nettype none

module clcd_front
    import clcd_pkg::*;
#(
    parameter int ROW_CAPACITY = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire in_item_t  in_data,
    input  wire logic [5:0] column_count,
    input  wire logic [2:0] row_count,
    input  wire logic      tall_font,
    input  wire logic      queue_full,
    output logic           push,
    output job_t           push_job
);

    localparam logic [3:0] ROW_LIMIT = 4'(ROW_CAPACITY - 1);

    logic       accept;
    logic [2:0] flags_reg;
    logic [2:0] flags_next;
    logic [2:0] flag_bit;
    logic [2:0] flags_upd;
    logic [3:0] row_a;
    logic [3:0] row_b;
    logic [6:0] row_off;
    logic [6:0] addr_sum;
    logic [2:0] slot_c;
    logic       valid_op;

    assign accept = in_valid && !queue_full;

    always_comb
    begin
        if (in_data.operation inside {OP_DISPLAY_ON, OP_DISPLAY_OFF})
            flag_bit = 3'b100;
        else if (in_data.operation inside {OP_CURSOR_ON, OP_CURSOR_OFF})
            flag_bit = 3'b010;
        else
            flag_bit = 3'b001;
        flags_upd = in_data.operation[0] ? (flags_reg | flag_bit) : (flags_reg & ~flag_bit);
    end

    always_comb
    begin
        row_a = (in_data.row > ROW_LIMIT) ? ROW_LIMIT : in_data.row;
        if (row_count == 3'd0)
            row_b = 4'd0;
        else if (row_a >= {1'b0, row_count})
            row_b = {1'b0, row_count} - 4'd1;
        else
            row_b = row_a;
        case (row_b[1:0])
            2'd0:    row_off = 7'h00;
            2'd1:    row_off = 7'h40;
            2'd2:    row_off = {1'b0, column_count};
            default: row_off = 7'h40 + {1'b0, column_count};
        endcase
        addr_sum = in_data.column + row_off;
        slot_c   = (in_data.glyph_slot > 4'd7) ? 3'd7 : in_data.glyph_slot[2:0];
    end

    always_comb
    begin
        valid_op           = 1'b1;
        flags_next         = flags_reg;
        push_job.kind      = JOB_SINGLE;
        push_job.rs        = 1'b0;
        push_job.long_wait = 1'b0;
        push_job.byte0     = CMD_CLEAR;
        push_job.fn_byte   = CMD_FUNCTION_SET;
        push_job.rows      = in_data.glyph_rows;
        if (row_count > 3'd1)
            push_job.fn_byte = push_job.fn_byte | FN_TWO_LINE;
        if (tall_font && row_count == 3'd1)
            push_job.fn_byte = push_job.fn_byte | FN_TALL_FONT;
        case (in_data.operation)
            OP_INIT:
            begin
                push_job.kind = JOB_INIT;
                flags_next    = 3'b100;
            end
            OP_CLEAR:
            begin
                push_job.byte0 = CMD_CLEAR;
            end
            OP_HOME:
            begin
                push_job.byte0     = CMD_HOME;
                push_job.long_wait = 1'b1;
            end
            OP_DISPLAY_ON, OP_DISPLAY_OFF, OP_CURSOR_ON, OP_CURSOR_OFF,
            OP_BLINK_ON, OP_BLINK_OFF:
            begin
                flags_next     = flags_upd;
                push_job.byte0 = {5'b00001, flags_upd};
            end
            OP_SCROLL_LEFT:
            begin
                push_job.byte0 = CMD_SCROLL_LEFT;
            end
            OP_SCROLL_RIGHT:
            begin
                push_job.byte0 = CMD_SCROLL_RIGHT;
            end
            OP_SET_CURSOR:
            begin
                push_job.byte0 = {1'b1, addr_sum};
            end
            OP_WRITE_CHAR:
            begin
                push_job.rs    = 1'b1;
                push_job.byte0 = in_data.char_code;
            end
            OP_DEFINE_GLYPH:
            begin
                push_job.kind  = JOB_GLYPH;
                push_job.byte0 = {2'b01, slot_c, 3'b000};
            end
            default:
            begin
                valid_op = 1'b0;
            end
        endcase
    end

    assign push = accept && valid_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= 3'b000;
        else if (accept)
            flags_reg <= flags_next;
    end

endmodule

`default_nettype wire

[src/clcd_queue.sv]
`default_nettype none

module clcd_queue
    import clcd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

[src/clcd_back.sv]
`default_nettype none

module clcd_back
    import clcd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire job_t q_job,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_item_t out_data
);

    logic      cur_valid_reg;
    job_t      cur_reg;
    logic [4:0] step_reg;
    logic      advance;
    logic      is_last;
    logic [7:0] cur_byte;
    logic [3:0] row_idx;
    out_item_t nib;
    logic      out_valid_reg;
    out_item_t out_reg;

    assign advance = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign pop     = !q_empty && (!cur_valid_reg || (advance && is_last));
    assign row_idx = step_reg[4:1] - 4'd1;

    always_comb
    begin
        cur_byte           = cur_reg.byte0;
        nib.register_select = 1'b0;
        nib.wait_before_us = '0;
        nib.wait_after_us  = '0;
        is_last            = (step_reg == 5'd1);
        case (cur_reg.kind)
            JOB_INIT:
            begin
                is_last = (step_reg == 5'd15);
                case (step_reg[3:1])
                    3'd0, 3'd1, 3'd2: cur_byte = CMD_WAKE;
                    3'd3:             cur_byte = CMD_FOUR_BIT;
                    3'd4:             cur_byte = cur_reg.fn_byte;
                    3'd5:             cur_byte = CMD_DISPLAY_INIT;
                    3'd6:             cur_byte = CMD_CLEAR;
                    default:          cur_byte = CMD_ENTRY_MODE;
                endcase
                if (step_reg == 5'd0)
                    nib.wait_before_us = WAIT_WAKE_FIRST;
                else if (step_reg == 5'd2)
                    nib.wait_before_us = WAIT_WAKE_SECOND;
                else if (step_reg == 5'd4)
                    nib.wait_before_us = WAIT_WAKE_THIRD;
                if (step_reg == 5'd7)
                    nib.wait_after_us = WAIT_FOUR_BIT;
                else if (step_reg == 5'd13)
                    nib.wait_after_us = WAIT_LONG_CMD;
            end
            JOB_GLYPH:
            begin
                is_last = (step_reg == 5'd17);
                if (step_reg >= 5'd2)
                begin
                    nib.register_select = 1'b1;
                    cur_byte = cur_reg.rows[{row_idx[2:0], 3'b000} +: 8];
                end
            end
            default:
            begin
                nib.register_select = cur_reg.rs;
                if (step_reg[0] && cur_reg.long_wait)
                    nib.wait_after_us = WAIT_LONG_CMD;
            end
        endcase
        nib.nibble = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
        nib.last   = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= '0;
            end
            else if (advance)
            begin
                if (is_last)
                    cur_valid_reg <= 1'b0;
                else
                    step_reg <= step_reg + 5'd1;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_job;
        if (advance)
            out_reg <= nib;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
